// File: sv/bfgt_pkg.sv
// Shared types and constants for the box face grid tessellator.
`default_nettype none
package bfgt_pkg;

  localparam int unsigned EXT_W     = 24;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned FACE_W    = 3;
  localparam int unsigned GRID_W    = 8;
  localparam int unsigned POS_W     = 25;
  localparam int unsigned HALF_W    = EXT_W - 1;
  localparam int unsigned TEX_W     = 17;
  localparam int unsigned VCNT_W    = 19;
  localparam int unsigned IDX_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = GRID_W + EXT_W;
  localparam int unsigned DIV_W     = 24;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned TEX_FRAC  = 16;

  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd4;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_Z = 3'd5;

  localparam logic [EXT_W-1:0] EXT_RESET = 24'd65536;
  localparam logic [SEG_W-1:0] SEG_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [EXT_W-1:0] box_width;
    logic [EXT_W-1:0] box_height;
    logic [EXT_W-1:0] box_depth;
    logic [SEG_W-1:0] segments_x;
    logic [SEG_W-1:0] segments_y;
    logic [SEG_W-1:0] segments_z;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage
`default_nettype wire

// File: sv/bfgt_cfg_regs.sv
// Configuration register file for the box extents and segment counts.
`default_nettype none
module bfgt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [bfgt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfgt_pkg::EXT_W-1:0]     cfg_data_i,
  output bfgt_pkg::cfg_t                 cfg_o
);
  import bfgt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_WIDTH:  cfg_d.box_width  = cfg_data_i;
        REG_BOX_HEIGHT: cfg_d.box_height = cfg_data_i;
        REG_BOX_DEPTH:  cfg_d.box_depth  = cfg_data_i;
        REG_SEGMENTS_X: cfg_d.segments_x = cfg_data_i[SEG_W-1:0];
        REG_SEGMENTS_Y: cfg_d.segments_y = cfg_data_i[SEG_W-1:0];
        REG_SEGMENTS_Z: cfg_d.segments_z = cfg_data_i[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_width  <= EXT_RESET;
      cfg_q.box_height <= EXT_RESET;
      cfg_q.box_depth  <= EXT_RESET;
      cfg_q.segments_x <= SEG_RESET;
      cfg_q.segments_y <= SEG_RESET;
      cfg_q.segments_z <= SEG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: sv/bfgt_div_lane.sv
// Bit-serial restoring divider lane: one quotient bit per cycle.
`default_nettype none
module bfgt_div_lane (
  input  logic                       clk_i,
  input  bfgt_pkg::div_ctrl_t        ctrl_i,
  input  logic [bfgt_pkg::SEG_W-1:0] rem_init_i,
  input  logic [bfgt_pkg::DIV_W-1:0] dividend_i,
  input  logic [bfgt_pkg::SEG_W-1:0] divisor_i,
  output logic [bfgt_pkg::DIV_W-1:0] quotient_o
);
  import bfgt_pkg::*;

  logic [SEG_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] shreg_q, shreg_d;
  logic [SEG_W-1:0] divisor_q;
  logic [SEG_W:0]   rem_shift;
  logic [SEG_W:0]   rem_diff;
  logic             qbit;

  always_comb begin
    rem_shift = {rem_q, shreg_q[DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor_q};
    qbit      = (rem_shift >= {1'b0, divisor_q});
    rem_d     = rem_q;
    shreg_d   = shreg_q;
    if (ctrl_i.load) begin
      rem_d   = rem_init_i;
      shreg_d = dividend_i;
    end else if (ctrl_i.step) begin
      rem_d   = qbit ? rem_diff[SEG_W-1:0] : rem_shift[SEG_W-1:0];
      shreg_d = {shreg_q[DIV_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shreg_q <= shreg_d;
    if (ctrl_i.load) begin
      divisor_q <= divisor_i;
    end
  end

  assign quotient_o = shreg_q;

endmodule
`default_nettype wire

// File: sv/box_face_grid_tessellator.sv
// Top level of the box face grid tessellator.
//
// Usage: configure box extents (Q8.16) and segment counts through the cfg
// channel while the block is idle. Each input beat names a face, a grid
// column and row, and an optional mesh restart. A beat on a valid grid
// point gives one output beat with the vertex position, normal, texture
// coordinates, running vertex index and quad indices; an empty face or a
// point off the grid gives no beat.
// Flow from input beat to output valid: one setup state with the column
// times extent multiply, then four parallel bit-serial divider lanes (one
// quotient bit per cycle) in the divide state, then a done state that
// forms the result. One item is in flight at a time, so a new input beat
// is taken only after the last one has left setup (no result) or done.
// The output register holds a finished vertex while the receiver stalls,
// and the next item may still be accepted and computed meanwhile.
// Reset clears the vertex counter and loads the reset extents and counts.
`default_nettype none
module box_face_grid_tessellator #(
  parameter int unsigned MAX_SEGMENTS = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfgt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfgt_pkg::EXT_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfgt_pkg::FACE_W-1:0]     face_i,
  input  logic [bfgt_pkg::GRID_W-1:0]     grid_col_i,
  input  logic [bfgt_pkg::GRID_W-1:0]     grid_row_i,
  input  logic                            start_mesh_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bfgt_pkg::POS_W-1:0] pos_x_o,
  output logic signed [bfgt_pkg::POS_W-1:0] pos_y_o,
  output logic signed [bfgt_pkg::POS_W-1:0] pos_z_o,
  output logic [bfgt_pkg::FACE_W-1:0]     normal_code_o,
  output logic [bfgt_pkg::TEX_W-1:0]      tex_u_o,
  output logic [bfgt_pkg::TEX_W-1:0]      tex_v_o,
  output logic [bfgt_pkg::VCNT_W-1:0]     vertex_index_o,
  output logic                            has_quad_o,
  output logic [bfgt_pkg::IDX_W-1:0]      index_right_o,
  output logic [bfgt_pkg::IDX_W-1:0]      index_above_o,
  output logic [bfgt_pkg::IDX_W-1:0]      index_diag_o,
  output logic                            reverse_winding_o
);
  import bfgt_pkg::*;

  localparam logic [SEG_W-1:0] SEG_CAP =
      (MAX_SEGMENTS > 255) ? {SEG_W{1'b1}} : SEG_W'(MAX_SEGMENTS);

  cfg_t      cfg;
  state_e    state_q, state_d;
  div_ctrl_t div_ctrl;
  logic      out_load;

  logic [FACE_W-1:0] face_q;
  logic [GRID_W-1:0] col_q, row_q;
  logic              start_q;

  logic [EXT_W-1:0]  sel_w, sel_h, sel_d;
  logic [SEG_W-1:0]  raw_sw, raw_sh, sel_sw, sel_sh;
  logic              face_ok, item_ok;
  logic [PROD_W-1:0] prod_a, prod_b;

  logic [SEG_W-1:0]  sw_q;
  logic [HALF_W-1:0] w_half_q, h_half_q, d_half_q;
  logic              quad_q;
  logic [VCNT_W-1:0] v_q;
  logic [VCNT_W-1:0] cnt_q, cnt_d, cnt_base;
  logic [STEP_W-1:0] step_q;

  logic [DIV_W-1:0]  quo_a, quo_b, quo_u, quo_v;

  logic signed [POS_W-1:0] res_a, res_b, res_dp, res_dn;
  logic signed [POS_W-1:0] res_x, res_y, res_z;
  logic [IDX_W-1:0]  res_right, res_above, res_diag;
  logic              res_rev;

  logic out_valid_q;

  assign cfg_ready_o = 1'b1;

  bfgt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      face_q  <= face_i;
      col_q   <= grid_col_i;
      row_q   <= grid_row_i;
      start_q <= start_mesh_i;
    end
  end

  always_comb begin
    face_ok = 1'b1;
    sel_w   = '0;
    sel_h   = '0;
    sel_d   = '0;
    raw_sw  = '0;
    raw_sh  = '0;
    case (face_q)
      FACE_TOP, FACE_BOTTOM: begin
        sel_w  = cfg.box_width;
        sel_h  = cfg.box_depth;
        sel_d  = cfg.box_height;
        raw_sw = cfg.segments_x;
        raw_sh = cfg.segments_z;
      end
      FACE_FRONT, FACE_BACK: begin
        sel_w  = cfg.box_width;
        sel_h  = cfg.box_height;
        sel_d  = cfg.box_depth;
        raw_sw = cfg.segments_x;
        raw_sh = cfg.segments_y;
      end
      FACE_LEFT, FACE_RIGHT: begin
        sel_w  = cfg.box_depth;
        sel_h  = cfg.box_height;
        sel_d  = cfg.box_width;
        raw_sw = cfg.segments_z;
        raw_sh = cfg.segments_y;
      end
      default: begin
        face_ok = 1'b0;
      end
    endcase
    sel_sw  = (raw_sw > SEG_CAP) ? SEG_CAP : raw_sw;
    sel_sh  = (raw_sh > SEG_CAP) ? SEG_CAP : raw_sh;
    item_ok = face_ok && (sel_w != '0) && (sel_h != '0) && (sel_sw != '0) &&
              (sel_sh != '0) && (col_q <= sel_sw) && (row_q <= sel_sh);
    prod_a  = PROD_W'(col_q) * PROD_W'(sel_w);
    prod_b  = PROD_W'(row_q) * PROD_W'(sel_h);
  end

  // The quotients stay below 2^24, so the top dividend byte seeds the remainder.
  bfgt_div_lane u_div_a (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .rem_init_i (prod_a[PROD_W-1:DIV_W]),
    .dividend_i (prod_a[DIV_W-1:0]),
    .divisor_i  (sel_sw),
    .quotient_o (quo_a)
  );

  bfgt_div_lane u_div_b (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .rem_init_i (prod_b[PROD_W-1:DIV_W]),
    .dividend_i (prod_b[DIV_W-1:0]),
    .divisor_i  (sel_sh),
    .quotient_o (quo_b)
  );

  bfgt_div_lane u_div_u (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .rem_init_i ('0),
    .dividend_i ({col_q, {TEX_FRAC{1'b0}}}),
    .divisor_i  (sel_sw),
    .quotient_o (quo_u)
  );

  bfgt_div_lane u_div_v (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .rem_init_i ('0),
    .dividend_i ({row_q, {TEX_FRAC{1'b0}}}),
    .divisor_i  (sel_sh),
    .quotient_o (quo_v)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP: state_d = item_ok ? ST_DIV : ST_IDLE;
      ST_DIV:   if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    div_ctrl.load = (state_q == ST_SETUP) && item_ok;
    div_ctrl.step = (state_q == ST_DIV);
    out_load      = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    cnt_base = start_q ? '0 : cnt_q;
    cnt_d    = cnt_q;
    if (state_q == ST_SETUP) begin
      cnt_d = item_ok ? cnt_base + VCNT_W'(1) : cnt_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((state_q == ST_DIV) && (state_d == ST_DIV)) begin
        step_q <= step_q + STEP_W'(1);
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ctrl.load) begin
      sw_q     <= sel_sw;
      w_half_q <= sel_w[EXT_W-1:1];
      h_half_q <= sel_h[EXT_W-1:1];
      d_half_q <= sel_d[EXT_W-1:1];
      quad_q   <= (col_q < sel_sw) && (row_q < sel_sh);
      v_q      <= cnt_base;
    end
  end

  always_comb begin
    res_a  = $signed({1'b0, quo_a}) - $signed({2'b00, w_half_q});
    res_b  = $signed({1'b0, quo_b}) - $signed({2'b00, h_half_q});
    res_dp = $signed({2'b00, d_half_q});
    res_dn = -res_dp;
    res_x  = res_a;
    res_y  = res_b;
    res_z  = res_dp;
    case (face_q)
      FACE_TOP: begin
        res_y = res_dp;
        res_z = res_b;
      end
      FACE_BOTTOM: begin
        res_y = res_dn;
        res_z = res_b;
      end
      FACE_FRONT: res_z = res_dp;
      FACE_BACK:  res_z = res_dn;
      FACE_LEFT: begin
        res_x = res_dn;
        res_z = res_a;
      end
      default: begin
        res_x = res_dp;
        res_z = res_a;
      end
    endcase
    res_rev   = quad_q && ((face_q == FACE_FRONT) || (face_q == FACE_LEFT) ||
                           (face_q == FACE_BOTTOM));
    res_right = quad_q ? {1'b0, v_q} + IDX_W'(1) : '0;
    res_above = quad_q ? {1'b0, v_q} + IDX_W'(sw_q) + IDX_W'(1) : '0;
    res_diag  = quad_q ? {1'b0, v_q} + IDX_W'(sw_q) + IDX_W'(2) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_o           <= res_x;
      pos_y_o           <= res_y;
      pos_z_o           <= res_z;
      normal_code_o     <= face_q;
      tex_u_o           <= quo_u[TEX_W-1:0];
      tex_v_o           <= quo_v[TEX_W-1:0];
      vertex_index_o    <= v_q;
      has_quad_o        <= quad_q;
      index_right_o     <= res_right;
      index_above_o     <= res_above;
      index_diag_o      <= res_diag;
      reverse_winding_o <= res_rev;
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DIV |-> step_q == '0)
    else $error("Divider step count left nonzero outside the divide phase.");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_SETUP)
    else $error("Accepted item did not enter setup.");

  a_no_quad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_quad_o |-> index_right_o == '0 && index_above_o == '0 &&
    index_diag_o == '0 && !reverse_winding_o)
    else $error("Quad fields set on a vertex without a quad.");

  a_quad_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_quad_o |-> index_right_o == {1'b0, vertex_index_o} + IDX_W'(1))
    else $error("Right index does not follow the vertex index.");

endmodule
`default_nettype wire
